[rtl/core/sdtq_pkg.sv]
// ---------------------------------------------------------------------------
// sdtq_pkg: shared constants for the sorted deadline timer queue
// Command codes, field widths and result constants.
// ---------------------------------------------------------------------------
package sdtq_pkg;

	localparam int TIME_W = 48;
	localparam int DUR_W  = 32;
	localparam int CMD_W  = 3;

	localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP        = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

	localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};
	localparam logic [DUR_W-1:0]  WAIT_INFINITE = 32'hFFFF_FFFF;
	localparam logic [DUR_W-1:0]  MAX_WAIT      = 32'hFFFF_FFFE;

endpackage

[rtl/core/sorted_deadline_timer_queue.sv]
// ---------------------------------------------------------------------------
// sorted_deadline_timer_queue: timers sorted by deadline in one memory
// Register, unregister, query, pop and clear over a deadline-ordered store.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transfer; m_axis returns one result per
//   command, in order. Time (now_ms) comes with every command.
//   Entries live in a synchronous memory (one read, one write port,
//   registered read). Register scans from the tail toward the head,
//   moving each later entry up one slot until the insert point is found.
//   Unregister scans from the head for the id, then shifts the rest down.
//   Pop shifts all entries down. Each scan or shift step is a read
//   followed by a write, and the finished result is then loaded into
//   the output register. Query reads only the head entry; clear,
//   unknown codes, a full register and an empty unregister or pop go
//   straight to the done state. The next command is taken once the
//   sequencer has handed its result to the output register and is idle.
//   The result sits in an output register until m_axis_tready takes it;
//   meanwhile the sequencer may finish one more command and then holds in
//   its last state, so a stalled receiver blocks the command after that.
//   Reset empties the queue (count to zero); memory contents are not cleared.
// ---------------------------------------------------------------------------
module sorted_deadline_timer_queue #(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [2:0] command, [10:3] timer_id, [42:11] duration_ms, [90:43] now_ms
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] ok, [8:1] popped_id, [40:9] timeout_ms
	output logic [47:0]  m_axis_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = sdtq_pkg::TIME_W;
	localparam int DW = sdtq_pkg::DUR_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REG  = 3'd1;
	localparam logic [2:0] ST_FIND = 3'd2;
	localparam logic [2:0] ST_SHD  = 3'd3;
	localparam logic [2:0] ST_QRY  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	typedef struct packed {
		logic [TW-1:0]       dl;
		logic [ID_WIDTH-1:0] id;
	} entry_t;

	entry_t mem [DEPTH];

	logic [2:0]          state_q;
	logic                phase_q;      // 0: issue read, 1: data back
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [2:0]          cmd_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [TW-1:0]       now_q;
	logic [TW-1:0]       end_q;
	entry_t              rd_q;
	logic                ok_q;
	logic [7:0]          pid_q;
	logic [DW-1:0]       wait_q;
	logic                ovalid_q;
	logic [47:0]         out_q;

	logic                we;
	logic [AW-1:0]       waddr;
	entry_t              wdata;
	logic [AW-1:0]       raddr;
	logic                load_out;

	// input field split
	logic [2:0]          in_cmd;
	logic [ID_WIDTH-1:0] in_id;
	logic [DW-1:0]       in_dur;
	logic [TW-1:0]       in_now;
	logic [TW:0]         sum;

	assign in_cmd = s_axis_tdata[2:0];
	assign in_id  = ID_WIDTH'(s_axis_tdata[3 +: ((ID_WIDTH < 8) ? ID_WIDTH : 8)]);
	assign in_dur = s_axis_tdata[42:11];
	assign in_now = s_axis_tdata[90:43];
	assign sum    = {1'b0, in_now} + {17'd0, in_dur};

	// finished result moves to the output register once it is free
	assign load_out      = (state_q == ST_DONE) && (!ovalid_q || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// read address follows the scan index
	always_comb begin
		raddr = idx_q[AW-1:0];
		if (state_q == ST_REG) raddr = AW'(idx_q - CW'(1));
		if (state_q == ST_SHD) raddr = AW'(idx_q + CW'(1));
	end

	// write port: shift one entry or place the new one
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rd_q;
		if (phase_q) begin
			unique case (state_q)
				ST_REG: begin
					we = 1'b1;
					if (idx_q != '0 && rd_q.dl > end_q) begin
						wdata = rd_q;
					end else begin
						wdata.dl = end_q;
						wdata.id = id_q;
					end
				end
				ST_SHD: begin
					we = (idx_q + CW'(1)) < count_q;
				end
				ST_IDLE, ST_FIND, ST_QRY, ST_DONE: we = 1'b0;
				default: we = 1'b0;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= 1'b0;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			out_q    <= '0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
				out_q    <= {7'd0, wait_q, pid_q, ok_q};
			end else if (m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						cmd_q   <= in_cmd;
						id_q    <= in_id;
						now_q   <= in_now;
						end_q   <= sum[TW] ? sdtq_pkg::TIME_MAX : sum[TW-1:0];
						ok_q    <= 1'b0;
						pid_q   <= '0;
						wait_q  <= '0;
						phase_q <= 1'b0;
						case (in_cmd)
							sdtq_pkg::CMD_REGISTER: begin
								if (count_q < CW'(DEPTH)) begin
									idx_q   <= count_q;
									state_q <= ST_REG;
								end else state_q <= ST_DONE;
							end
							sdtq_pkg::CMD_UNREGISTER: begin
								idx_q   <= '0;
								state_q <= (count_q == '0) ? ST_DONE : ST_FIND;
							end
							sdtq_pkg::CMD_POP: begin
								idx_q   <= '0;
								if (count_q != '0) begin
									ok_q    <= 1'b1;
									state_q <= ST_FIND;
								end else state_q <= ST_DONE;
							end
							sdtq_pkg::CMD_QUERY: begin
								idx_q   <= '0;
								ok_q    <= 1'b1;
								state_q <= ST_QRY;
							end
							sdtq_pkg::CMD_CLEAR: begin
								count_q <= '0;
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_REG: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (idx_q != '0 && rd_q.dl > end_q) begin
							idx_q <= idx_q - CW'(1);
						end else begin
							count_q <= count_q + CW'(1);
							ok_q    <= 1'b1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_FIND: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (cmd_q == sdtq_pkg::CMD_POP) begin
							pid_q   <= 8'(rd_q.id);
							state_q <= ST_SHD;
						end else if (rd_q.id == id_q) begin
							ok_q    <= 1'b1;
							state_q <= ST_SHD;
						end else if (idx_q + CW'(1) >= count_q) begin
							state_q <= ST_DONE;
						end else idx_q <= idx_q + CW'(1);
					end
				end
				ST_SHD: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (idx_q + CW'(2) >= count_q) begin
							count_q <= count_q - CW'(1);
							state_q <= ST_DONE;
						end else idx_q <= idx_q + CW'(1);
					end
				end
				ST_QRY: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (count_q == '0) wait_q <= sdtq_pkg::WAIT_INFINITE;
						else if (now_q >= rd_q.dl) wait_q <= '0;
						else if ((rd_q.dl - now_q) > {16'd0, sdtq_pkg::MAX_WAIT})
							wait_q <= sdtq_pkg::MAX_WAIT;
						else wait_q <= DW'(rd_q.dl - now_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("count above depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> ovalid_q) else $error("result lost");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHD) |-> (count_q != '0)) else $error("shift on empty queue");
`endif

endmodule

[verif/sorted_deadline_timer_queue_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_deadline_timer_queue_tb: self-checking bench for the timer queue
// Drives command transfers with random gaps, mirrors the sorted store in a
// behavioral queue model and checks every result transfer field by field.
// ---------------------------------------------------------------------------
module sorted_deadline_timer_queue_tb;

	localparam int QDEPTH = 16;

	// packed from the lowest bit up: ok, popped_id, timeout_ms
	typedef struct packed {
		logic [sdtq_pkg::DUR_W-1:0] timeout_ms;
		logic [7:0]                 popped_id;
		logic                       ok;
	} timer_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [47:0]  m_axis_tdata;

	// shadow copy of the timer store
	logic [sdtq_pkg::TIME_W-1:0] shadow_deadline[$];
	logic [7:0]                  shadow_id[$];
	timer_result_t               pending_results[$];

	int  mismatches = 0;
	bit  sink_hold = 0;
	bit  idle_free = 0;
	logic [sdtq_pkg::TIME_W-1:0] clock_ms;

	sorted_deadline_timer_queue #(.DEPTH(QDEPTH), .ID_WIDTH(8)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// expected result of one command, updating the shadow store
	function automatic timer_result_t apply_timer_cmd(logic [2:0] cmd, logic [7:0] id,
			logic [sdtq_pkg::DUR_W-1:0] dur, logic [sdtq_pkg::TIME_W-1:0] now);
		timer_result_t r;
		logic [sdtq_pkg::TIME_W:0] sum;
		logic [sdtq_pkg::TIME_W-1:0] due;
		int pos;
		r = '0;
		case (cmd)
			sdtq_pkg::CMD_REGISTER: begin
				sum = now + dur;
				due = sum[sdtq_pkg::TIME_W] ? sdtq_pkg::TIME_MAX
					: sum[sdtq_pkg::TIME_W-1:0];
				if (shadow_deadline.size() < QDEPTH) begin
					pos = shadow_deadline.size();
					for (int k = 0; k < shadow_deadline.size(); k++)
						if (shadow_deadline[k] > due) begin
							pos = k;
							break;
						end
					shadow_deadline.insert(pos, due);
					shadow_id.insert(pos, id);
					r.ok = 1;
				end
			end
			sdtq_pkg::CMD_UNREGISTER: begin
				for (int k = 0; k < shadow_id.size(); k++)
					if (shadow_id[k] == id) begin
						shadow_id.delete(k);
						shadow_deadline.delete(k);
						r.ok = 1;
						break;
					end
			end
			sdtq_pkg::CMD_QUERY: begin
				r.ok = 1;
				if (shadow_deadline.size() == 0)
					r.timeout_ms = sdtq_pkg::WAIT_INFINITE;
				else if (now >= shadow_deadline[0])
					r.timeout_ms = '0;
				else if (shadow_deadline[0] - now > sdtq_pkg::MAX_WAIT)
					r.timeout_ms = sdtq_pkg::MAX_WAIT;
				else
					r.timeout_ms = sdtq_pkg::DUR_W'(shadow_deadline[0] - now);
			end
			sdtq_pkg::CMD_POP: begin
				if (shadow_id.size() > 0) begin
					r.popped_id = shadow_id.pop_front();
					void'(shadow_deadline.pop_front());
					r.ok = 1;
				end
			end
			sdtq_pkg::CMD_CLEAR: begin
				shadow_id.delete();
				shadow_deadline.delete();
				r.ok = 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// send one command transfer; valid stays up until the next call or a drain
	task automatic send_cmd(logic [2:0] cmd, logic [7:0] id,
			logic [sdtq_pkg::DUR_W-1:0] dur, logic [sdtq_pkg::TIME_W-1:0] now);
		while (!idle_free && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'b0, now, dur, id, cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(apply_timer_cmd(cmd, id, dur, now));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2 * QDEPTH + 8) @(negedge clk);
	endtask

	// receiver ready, with random stalls and forced hold-offs
	always @(negedge clk) begin
		if (!arst_n || sink_hold)
			m_axis_tready <= 0;
		else
			m_axis_tready <= idle_free || ($urandom_range(99) >= 20);
	end

	// result checker
	always @(posedge clk) begin
		timer_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[40:0];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok || got.popped_id !== want.popped_id
						|| got.timeout_ms !== want.timeout_ms) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ok=%b id=%h to=%h, got ok=%b id=%h to=%h",
							want.ok, want.popped_id, want.timeout_ms,
							got.ok, got.popped_id, got.timeout_ms);
				end
			end
		end
	end

	// extremes, every command, full store, ties, saturation, bad codes
	task automatic test_directed();
		send_cmd(sdtq_pkg::CMD_QUERY, 8'h00, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_POP, 8'h00, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_UNREGISTER, 8'hFF, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_REGISTER, 8'hFF, 32'hFFFF_FFFF, sdtq_pkg::TIME_MAX);
		send_cmd(sdtq_pkg::CMD_QUERY, 8'h00, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_REGISTER, 8'h00, 32'd0, 48'd100);
		send_cmd(sdtq_pkg::CMD_REGISTER, 8'h01, 32'd0, 48'd100);
		send_cmd(sdtq_pkg::CMD_QUERY, 8'h00, '0, 48'd100);
		send_cmd(sdtq_pkg::CMD_QUERY, 8'h00, '0, 48'd40);
		send_cmd(sdtq_pkg::CMD_POP, 8'h00, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_UNREGISTER, 8'hFF, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_POP, 8'h00, '0, 48'd0);
		send_cmd(sdtq_pkg::CMD_QUERY, 8'h00, '0, 48'd0);
		send_cmd(3'd5, 8'hAA, 32'h5555_AAAA, 48'h1234);
		send_cmd(3'd7, 8'h55, 32'hAAAA_5555, 48'h4321);
		for (int k = 0; k < QDEPTH + 1; k++)
			send_cmd(sdtq_pkg::CMD_REGISTER, 8'(k), 32'(k % 3), 48'd7);
		send_cmd(sdtq_pkg::CMD_CLEAR, 8'h00, '0, 48'd0);
	endtask

	// random mix: mostly valid commands against a running clock
	task automatic test_random(int n);
		logic [2:0]  cmd;
		logic [7:0]  id;
		logic [sdtq_pkg::DUR_W-1:0] dur;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40) cmd = sdtq_pkg::CMD_REGISTER;
			else if (r < 55) cmd = sdtq_pkg::CMD_UNREGISTER;
			else if (r < 75) cmd = sdtq_pkg::CMD_QUERY;
			else if (r < 92) cmd = sdtq_pkg::CMD_POP;
			else if (r < 96) cmd = sdtq_pkg::CMD_CLEAR;
			else cmd = 3'($urandom_range(5, 7));
			id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
			case ($urandom_range(3))
				0: dur = $urandom;
				1: dur = 32'hFFFF_FFFF;
				default: dur = $urandom_range(1000);
			endcase
			if ($urandom_range(49) == 0)
				clock_ms = 48'({$urandom, $urandom} >> 16);
			else
				clock_ms = clock_ms + $urandom_range(400);
			send_cmd(cmd, id, dur, clock_ms);
		end
	endtask

	// receiver held off while commands pile up
	task automatic test_backpressure();
		sink_hold = 1;
		fork
			test_random(6);
			begin
				repeat (300) @(negedge clk);
				sink_hold = 0;
			end
		join
		wait_drained();
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		clock_ms = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		wait_drained();
		test_random(800);
		test_backpressure();
		idle_free = 1;
		test_random(300);
		idle_free = 0;
		test_random(800);
		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
